@@ hw/rtl/pcs_pkg.sv @@
// Shared types and constants for the periodic callback scheduler.
package pcs_pkg;

    localparam int MaxEntries  = 8;
    localparam int SlotBits    = 3;
    localparam int CountBits   = 4;
    localparam int KeyBits     = 16;
    localparam int IntervalBits = 32;

    typedef enum logic [2:0] {
        FUNC_TICK   = 3'd0,
        FUNC_ADD    = 3'd1,
        FUNC_REMOVE = 3'd2,
        FUNC_CLEAR  = 3'd3,
        FUNC_READ   = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        KIND_STATUS  = 2'd0,
        KIND_FIRE    = 2'd1,
        KIND_NOFIRE  = 2'd2,
        KIND_READ    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_EMIT,
        ST_DONE
    } state_t;

endpackage

@@ hw/rtl/periodic_callback_scheduler.sv @@
// Top level of the periodic callback scheduler with its sequencer and shared divider.
//
// The block keeps a 32-bit tick counter and a packed table of eight entries
// (key and interval). Input words arrive on the s_ stream; s_tuser carries
// func and tdata carries key, interval and slot. Result words leave on the
// m_ stream with the result kind on m_tuser and tlast set on the final result
// of an input word.
//
// Add, remove, clear and read take one word each: add and remove walk the
// table one slot per cycle. A tick walks the live entries in slot order and
// runs one shared restoring divider on each nonzero interval, one quotient
// bit per cycle. A fire word is held until the next fire or the end of the
// walk so the final one can carry tlast.
// The block takes one input word at a time and is not ready meanwhile.
// Each result sits in an output register until the receiver takes it; a
// stall on m_tready holds the sequencer at that result.
// After a synchronous reset (aresetn low) the counter, the entry count and
// the table are zero and the block is ready at once.
module periodic_callback_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // func[2:0]
    input  logic [2:0]  s_tuser,
    // key[15:0], interval[47:16], slot[50:48], zero fill
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_kind[1:0]
    output logic [1:0]  m_tuser,
    // ok[0], key_out[16:1], slot_out[19:17], interval_out[51:20],
    // entries_in_use[55:52]
    output logic [55:0] m_tdata,
    output logic        m_tlast
);

    localparam int SB = pcs_pkg::SlotBits;
    localparam int CB = pcs_pkg::CountBits;
    localparam int KB = pcs_pkg::KeyBits;
    localparam int IB = pcs_pkg::IntervalBits;
    localparam int DivCntBits = 6;

    pcs_pkg::state_t state_reg, state_next;

    logic [IB-1:0] tick_reg;
    logic [CB-1:0] count_reg;
    logic [KB-1:0] key_reg [pcs_pkg::MaxEntries];
    logic [IB-1:0] ival_reg [pcs_pkg::MaxEntries];

    // Latched input word.
    logic [2:0]    func_reg;
    logic [KB-1:0] in_key_reg;
    logic [IB-1:0] in_ival_reg;
    logic [SB-1:0] in_slot_reg;

    // Scan index and fire tracking.
    logic [CB-1:0] idx_reg;
    logic          fired_reg;
    logic          found_reg;

    // Fire word held back until it is known whether it is the last one.
    logic [KB-1:0] hold_key_reg;
    logic [SB-1:0] hold_slot_reg;
    logic [IB-1:0] hold_ival_reg;

    // Shared divider: remainder and quotient-bit count.
    logic [IB:0]   rem_reg;
    logic [IB-1:0] dvd_reg;
    logic [DivCntBits-1:0] dcnt_reg;

    // Output register.
    logic          mv_reg;
    logic [1:0]    o_kind_reg;
    logic          o_ok_reg;
    logic [KB-1:0] o_key_reg;
    logic [SB-1:0] o_slot_reg;
    logic [IB-1:0] o_ival_reg;
    logic          o_last_reg;

    // Value loaded into the output register.
    logic          o_load;
    logic [1:0]    o_kind_next;
    logic          o_ok_next;
    logic [KB-1:0] o_key_next;
    logic [SB-1:0] o_slot_next;
    logic [IB-1:0] o_ival_next;
    logic          o_last_next;

    logic          s_acc, m_acc, out_free;
    logic [SB-1:0] idx_slot;
    logic [IB:0]   trial;
    logic          scan_end;
    logic          add_ok;

    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    assign out_free = !mv_reg || m_tready;
    assign idx_slot = idx_reg[SB-1:0];
    assign scan_end = (idx_reg >= count_reg);
    assign trial    = {rem_reg[IB-1:0], dvd_reg[IB-1]} - {1'b0, ival_reg[idx_slot]};
    assign add_ok   = !found_reg && (count_reg < CB'(pcs_pkg::MaxEntries));

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pcs_pkg::ST_IDLE: begin
                if (s_acc) begin
                    state_next = pcs_pkg::ST_SCAN;
                end
            end
            pcs_pkg::ST_SCAN: begin
                if (func_reg == pcs_pkg::FUNC_TICK) begin
                    if (scan_end) begin
                        state_next = pcs_pkg::ST_DONE;
                    end else if (ival_reg[idx_slot] != '0) begin
                        state_next = pcs_pkg::ST_DIV;
                    end
                end else if (func_reg == pcs_pkg::FUNC_ADD ||
                             func_reg == pcs_pkg::FUNC_REMOVE) begin
                    if (scan_end || (in_key_reg == key_reg[idx_slot])) begin
                        state_next = pcs_pkg::ST_DONE;
                    end
                end else begin
                    state_next = pcs_pkg::ST_DONE;
                end
            end
            pcs_pkg::ST_DIV: begin
                if (dcnt_reg == DivCntBits'(IB - 1)) begin
                    state_next = pcs_pkg::ST_EMIT;
                end
            end
            pcs_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = pcs_pkg::ST_SCAN;
                end
            end
            pcs_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = pcs_pkg::ST_IDLE;
                end
            end
            default: state_next = pcs_pkg::ST_IDLE;
        endcase
    end

    // Output decode of the state.
    always_comb begin
        s_tready = 1'b0;
        case (state_reg)
            pcs_pkg::ST_IDLE: s_tready = 1'b1;
            default:          s_tready = 1'b0;
        endcase
    end

    // Result word to load: a released fire word, or the closing word.
    always_comb begin
        o_load      = 1'b0;
        o_kind_next = pcs_pkg::KIND_STATUS;
        o_ok_next   = 1'b0;
        o_key_next  = '0;
        o_slot_next = '0;
        o_ival_next = '0;
        o_last_next = 1'b1;
        case (state_reg)
            pcs_pkg::ST_EMIT: begin
                // A new fire releases the one held before it.
                o_load      = out_free && (rem_reg == '0) && fired_reg;
                o_kind_next = pcs_pkg::KIND_FIRE;
                o_key_next  = hold_key_reg;
                o_slot_next = hold_slot_reg;
                o_ival_next = hold_ival_reg;
                o_last_next = 1'b0;
            end
            pcs_pkg::ST_DONE: begin
                o_load = out_free;
                case (func_reg)
                    pcs_pkg::FUNC_TICK: begin
                        // Close the run: the held fire word carries tlast, or report none.
                        if (fired_reg) begin
                            o_kind_next = pcs_pkg::KIND_FIRE;
                            o_key_next  = hold_key_reg;
                            o_slot_next = hold_slot_reg;
                            o_ival_next = hold_ival_reg;
                        end else begin
                            o_kind_next = pcs_pkg::KIND_NOFIRE;
                        end
                    end
                    pcs_pkg::FUNC_ADD:    o_ok_next = add_ok;
                    pcs_pkg::FUNC_REMOVE: o_ok_next = found_reg;
                    pcs_pkg::FUNC_CLEAR:  o_ok_next = 1'b1;
                    pcs_pkg::FUNC_READ: begin
                        o_kind_next = pcs_pkg::KIND_READ;
                        o_key_next  = key_reg[in_slot_reg];
                        o_slot_next = in_slot_reg;
                        o_ival_next = ival_reg[in_slot_reg];
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pcs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else begin
            if (o_load) begin
                mv_reg <= 1'b1;
            end else if (m_acc) begin
                mv_reg <= 1'b0;
            end
            if (o_load) begin
                o_kind_reg <= o_kind_next;
                o_ok_reg   <= o_ok_next;
                o_key_reg  <= o_key_next;
                o_slot_reg <= o_slot_next;
                o_ival_reg <= o_ival_next;
                o_last_reg <= o_last_next;
            end
        end
    end

    // Datapath: table, counter and divider.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg  <= '0;
            count_reg <= '0;
            for (int i = 0; i < pcs_pkg::MaxEntries; i++) begin
                key_reg[i]  <= '0;
                ival_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                pcs_pkg::ST_IDLE: begin
                    if (s_acc) begin
                        func_reg    <= s_tuser;
                        in_key_reg  <= s_tdata[15:0];
                        in_ival_reg <= s_tdata[47:16];
                        in_slot_reg <= s_tdata[50:48];
                        idx_reg     <= '0;
                        fired_reg   <= 1'b0;
                        found_reg   <= 1'b0;
                        if (s_tuser == pcs_pkg::FUNC_TICK) begin
                            tick_reg <= tick_reg + 1'b1;
                        end
                    end
                end
                pcs_pkg::ST_SCAN: begin
                    if (func_reg == pcs_pkg::FUNC_TICK) begin
                        if (!scan_end) begin
                            if (ival_reg[idx_slot] != '0) begin
                                rem_reg  <= '0;
                                dvd_reg  <= tick_reg;
                                dcnt_reg <= '0;
                            end else begin
                                idx_reg <= idx_reg + 1'b1;
                            end
                        end
                    end else if (func_reg == pcs_pkg::FUNC_ADD ||
                                 func_reg == pcs_pkg::FUNC_REMOVE) begin
                        if (!scan_end && in_key_reg == key_reg[idx_slot]) begin
                            found_reg <= 1'b1;
                        end else if (!scan_end) begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                pcs_pkg::ST_DIV: begin
                    // One restoring step: shift in a dividend bit, subtract if it fits.
                    dvd_reg  <= {dvd_reg[IB-2:0], 1'b0};
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (!trial[IB]) begin
                        rem_reg <= trial;
                    end else begin
                        rem_reg <= {rem_reg[IB-1:0], dvd_reg[IB-1]};
                    end
                end
                pcs_pkg::ST_EMIT: begin
                    if (out_free) begin
                        idx_reg <= idx_reg + 1'b1;
                        if (rem_reg == '0) begin
                            fired_reg     <= 1'b1;
                            hold_key_reg  <= key_reg[idx_slot];
                            hold_slot_reg <= idx_slot;
                            hold_ival_reg <= ival_reg[idx_slot];
                        end
                    end
                end
                pcs_pkg::ST_DONE: begin
                    if (out_free) begin
                        case (func_reg)
                            pcs_pkg::FUNC_ADD: begin
                                if (add_ok) begin
                                    key_reg[count_reg[SB-1:0]]  <= in_key_reg;
                                    ival_reg[count_reg[SB-1:0]] <= in_ival_reg;
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            pcs_pkg::FUNC_REMOVE: begin
                                if (found_reg) begin
                                    key_reg[idx_slot]  <= key_reg[SB'(count_reg - 1'b1)];
                                    ival_reg[idx_slot] <= ival_reg[SB'(count_reg - 1'b1)];
                                    count_reg <= count_reg - 1'b1;
                                end
                            end
                            pcs_pkg::FUNC_CLEAR: begin
                                count_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // Entries count after add/remove is shown live from count_reg on the
    // status word: it changes only at the edge that loads a new word.
    logic [CB-1:0] count_shown;
    always_comb begin
        count_shown = count_reg;
    end

    assign m_tvalid = mv_reg;
    assign m_tlast  = o_last_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tdata  = {count_shown, o_ival_reg, o_slot_reg, o_key_reg, o_ok_reg};

    // The input side is closed whenever the sequencer is busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != pcs_pkg::ST_IDLE) |-> !s_tready)
        else $error("input ready while busy");

    // The entry count never exceeds the table size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CB'(pcs_pkg::MaxEntries))
        else $error("entry count overflow");

    // A held result is never overwritten while the receiver stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && !m_tready) |=> (mv_reg && $stable(o_ival_reg) && $stable(o_key_reg)))
        else $error("stalled result changed");

endmodule

@@ tb/pcs_checker.sv @@
// Result checker for the periodic callback scheduler: predicts each result and compares.
`timescale 1ns / 100ps

module pcs_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [2:0]  s_tuser,
    input  logic [55:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [1:0]  m_tuser,
    input  logic [55:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [3:0]  entries;
        logic [31:0] interval;
        logic [2:0]  slot;
        logic [15:0] key;
        logic        ok;
        logic [1:0]  kind;
        logic        last;
    } result_t;

    // Shadow copy of the scheduler state.
    logic [31:0] ticks;
    logic [3:0]  used;
    logic [15:0] keys [pcs_pkg::MaxEntries];
    logic [31:0] ivals [pcs_pkg::MaxEntries];
    result_t     expected_results [$];

    function automatic result_t make_result(logic [1:0] kind, logic ok, logic [15:0] key,
                                            logic [2:0] slot, logic [31:0] ival);
        result_t r;
        r.kind = kind;
        r.ok = ok;
        r.key = key;
        r.slot = slot;
        r.interval = ival;
        r.entries = used;
        r.last = 1'b0;
        return r;
    endfunction

    // Apply one input word to the shadow state and queue its results.
    task automatic predict_word(logic [2:0] fn, logic [55:0] w);
        logic [15:0] key;
        logic [31:0] ival;
        logic [2:0]  slot;
        logic        good;
        int          n;
        key = w[15:0];
        ival = w[47:16];
        slot = w[50:48];
        n = 0;
        good = 1'b0;
        case (fn)
            pcs_pkg::FUNC_TICK: begin
                ticks = ticks + 1;
                for (int i = 0; i < used; i++) begin
                    if (ivals[i] != 0 && (ticks % ivals[i]) == 0) begin
                        expected_results.push_back(make_result(pcs_pkg::KIND_FIRE, 1'b0,
                                                               keys[i], 3'(i), ivals[i]));
                        n++;
                    end
                end
                if (n == 0)
                    expected_results.push_back(make_result(pcs_pkg::KIND_NOFIRE, 1'b0,
                                                           '0, '0, '0));
            end
            pcs_pkg::FUNC_ADD: begin
                good = used < pcs_pkg::MaxEntries;
                for (int i = 0; i < used; i++)
                    if (keys[i] == key) good = 1'b0;
                if (good) begin
                    keys[used] = key;
                    ivals[used] = ival;
                    used = used + 1'b1;
                end
                expected_results.push_back(make_result(pcs_pkg::KIND_STATUS, good,
                                                       '0, '0, '0));
            end
            pcs_pkg::FUNC_REMOVE: begin
                for (int i = 0; i < used; i++) begin
                    if (!good && keys[i] == key) begin
                        keys[i] = keys[used - 1'b1];
                        ivals[i] = ivals[used - 1'b1];
                        used = used - 1'b1;
                        good = 1'b1;
                    end
                end
                expected_results.push_back(make_result(pcs_pkg::KIND_STATUS, good,
                                                       '0, '0, '0));
            end
            pcs_pkg::FUNC_CLEAR: begin
                used = '0;
                expected_results.push_back(make_result(pcs_pkg::KIND_STATUS, 1'b1,
                                                       '0, '0, '0));
            end
            pcs_pkg::FUNC_READ:
                expected_results.push_back(make_result(pcs_pkg::KIND_READ, 1'b0, keys[slot],
                                                       slot, ivals[slot]));
            default:
                expected_results.push_back(make_result(pcs_pkg::KIND_STATUS, 1'b0,
                                                       '0, '0, '0));
        endcase
        expected_results[$].last = 1'b1;
    endtask

    // Watch both channels at the rising edge.
    always @(posedge aclk) begin
        result_t exp_r;
        result_t got;
        if (!aresetn) begin
            ticks = '0;
            used = '0;
            for (int i = 0; i < pcs_pkg::MaxEntries; i++) begin
                keys[i] = '0;
                ivals[i] = '0;
            end
            expected_results.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.kind = m_tuser;
                got.ok = m_tdata[0];
                got.key = m_tdata[16:1];
                got.slot = m_tdata[19:17];
                got.interval = m_tdata[51:20];
                got.entries = m_tdata[55:52];
                got.last = m_tlast;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result word %h kind %0d last %b", $realtime,
                             m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: mismatch kind/ok/key/slot/ival/cnt/last", $realtime);
                        $display("    expected %0d %0d %h %0d %h %0d %0d", exp_r.kind,
                                 exp_r.ok, exp_r.key, exp_r.slot, exp_r.interval,
                                 exp_r.entries, exp_r.last);
                        $display("    actual   %0d %0d %h %0d %h %0d %0d", got.kind,
                                 got.ok, got.key, got.slot, got.interval, got.entries,
                                 got.last);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_word(s_tuser, s_tdata);
        end
        pending = expected_results.size();
    end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the periodic callback scheduler: stimulus, clock, reset and verdict.
`timescale 1ns / 100ps

module tb_top;

    localparam int IdleLimit = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [2:0]  s_tuser;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [1:0]  m_tuser;
    logic [55:0] m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    logic [15:0] key_pool [6];

    periodic_callback_scheduler uut (.*);

    pcs_checker chk (.*);

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Watchdog: cycles in which no word moves on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Receiver stalls in its own pattern, with stall-free stretches.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            case ($urandom_range(0, 3))
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 1) != 0);
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
            repeat ($urandom_range(0, 20)) @(negedge aclk);
        end
    end

    // Send one word and wait for its acceptance.
    task automatic send_word(logic [2:0] fn, logic [15:0] key, logic [31:0] ival,
                             logic [2:0] slot);
        s_tuser <= fn;
        s_tdata <= {5'b00000, slot, ival, key};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic pause_sender(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_interval();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return $urandom();
            2: return 32'hFFFF_FFFF;
            default: return 32'($urandom_range(1, 12));
        endcase
    endfunction

    initial begin
        logic [2:0]  fn;
        logic [15:0] key;
        int          sent;
        int          burst;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part: reads of reset contents, extremes and each special case.
        send_word(pcs_pkg::FUNC_READ, 16'hFFFF, 32'hFFFF_FFFF, 3'd7);
        send_word(pcs_pkg::FUNC_TICK, '0, '0, '0);
        send_word(pcs_pkg::FUNC_REMOVE, 16'h1234, '0, '0);
        send_word(pcs_pkg::FUNC_ADD, 16'h0000, 32'd1, '0);
        send_word(pcs_pkg::FUNC_ADD, 16'hFFFF, 32'd0, '0);
        send_word(pcs_pkg::FUNC_ADD, 16'hFFFF, 32'd2, '0);
        send_word(pcs_pkg::FUNC_ADD, 16'hAAAA, 32'hFFFF_FFFF, '0);
        send_word(pcs_pkg::FUNC_ADD, 16'h5555, 32'd2, '0);
        for (int i = 0; i < 4; i++)
            send_word(pcs_pkg::FUNC_ADD, 16'(16'h0100 + i), 32'(i + 1), '0);
        send_word(pcs_pkg::FUNC_ADD, 16'h7777, 32'd3, '0);
        send_word(pcs_pkg::FUNC_TICK, '0, '0, '0);
        send_word(pcs_pkg::FUNC_TICK, '0, '0, '0);
        send_word(pcs_pkg::FUNC_READ, '0, '0, 3'd7);
        send_word(pcs_pkg::FUNC_REMOVE, 16'h0000, '0, '0);
        send_word(pcs_pkg::FUNC_REMOVE, 16'h0000, '0, '0);
        send_word(3'd5, 16'hFFFF, 32'hFFFF_FFFF, 3'd7);
        send_word(3'd6, '0, '0, '0);
        send_word(3'd7, '0, '0, '0);
        send_word(pcs_pkg::FUNC_CLEAR, '0, '0, '0);
        send_word(pcs_pkg::FUNC_READ, '0, '0, 3'd3);
        send_word(pcs_pkg::FUNC_TICK, '0, '0, '0);

        // Sender holds off until the block has drained.
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);

        // Random part: table traffic with ticks dominating and some undefined func codes.
        for (int i = 0; i < 6; i++)
            key_pool[i] = 16'($urandom());
        sent = 0;
        while (sent < 480) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst; b++) begin
                key = ($urandom_range(0, 7) == 0) ? 16'($urandom())
                                                  : key_pool[$urandom_range(0, 5)];
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4: fn = pcs_pkg::FUNC_ADD;
                    5, 6: fn = pcs_pkg::FUNC_REMOVE;
                    7: fn = ($urandom_range(0, 3) == 0) ? pcs_pkg::FUNC_CLEAR
                                                        : pcs_pkg::FUNC_READ;
                    8: fn = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(5, 7))
                                                        : pcs_pkg::FUNC_READ;
                    default: fn = pcs_pkg::FUNC_TICK;
                endcase
                send_word(fn, key, pick_interval(), 3'($urandom()));
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                pause_sender($urandom_range(1, 30));
        end
        s_tvalid <= 1'b0;

        // Drain and let the block settle.
        while (pending != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
